// ----- hw/rtl/rls_pkg.sv -----
package rls_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LEVELS_DEF = 32;
  localparam int DIM_BITS_DEF   = 31;

  // Fixed field widths on the ports
  localparam int FIELD_W     = 31;
  localparam int LEVEL_W     = 6;
  localparam int REQ_TYPE_W  = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  // Rounding modes; the unused code behaves as closest
  localparam logic [REQ_TYPE_W-1:0] MODE_CLOSEST = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] MODE_UP      = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] MODE_DOWN    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture request, start at full size
    logic step;  // evaluate current reduction, advance to the next
    logic emit;  // move the choice into the output register
  } rls_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;  // current reduction is the last one to evaluate
  } rls_stat_t;

endpackage

// ----- hw/rtl/rls_ctrl.sv -----
module rls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  rls_pkg::rls_stat_t stat,
  output rls_pkg::rls_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   o_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = o_valid;

  always_comb begin
    cmd.load = s_tvalid && s_tready;
    cmd.step = (state == S_SCAN);
    cmd.emit = (state == S_DONE) && (!o_valid || m_tready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd.load) state_next = S_SCAN;
      S_SCAN:  if (stat.last) state_next = S_FLUSH;
      S_FLUSH: state_next = S_DONE;
      S_DONE:  if (cmd.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // an accepted request starts evaluating in the next cycle
  a_load_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.step)
    else $error("request accepted but scan did not start");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while pending");

  // the scan cannot run past the flush into the output
  a_flush_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && stat.last) |=> (!cmd.step && !cmd.emit))
    else $error("scan did not stop after last reduction");

endmodule

// ----- hw/rtl/rls_dp.sv -----
module rls_dp #(
  parameter int MAX_LEVELS = rls_pkg::MAX_LEVELS_DEF,
  parameter int DIM_BITS   = rls_pkg::DIM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rls_pkg::rls_cmd_t               cmd,
  output rls_pkg::rls_stat_t              stat,
  input  logic [DIM_BITS-1:0]             image_width,
  input  logic [DIM_BITS-1:0]             image_height,
  input  logic [rls_pkg::LEVEL_W-1:0]     level_count,
  input  logic [rls_pkg::REQ_TYPE_W-1:0]  req_type,
  input  logic [rls_pkg::FIELD_W-1:0]     req_width,
  input  logic [rls_pkg::FIELD_W-1:0]     req_height,
  output logic [rls_pkg::LEVEL_W-1:0]     level,
  output logic [rls_pkg::FIELD_W-1:0]     res_width,
  output logic [rls_pkg::FIELD_W-1:0]     res_height
);

  localparam int RW = $clog2(MAX_LEVELS + 1);

  // request and scan registers
  logic [rls_pkg::REQ_TYPE_W-1:0] mode;
  logic [DIM_BITS-1:0] rw, rh;
  logic [DIM_BITS-1:0] x, y;
  logic [RW-1:0]       r, nl_q;

  // evaluation stage
  logic                ev_valid;
  logic [DIM_BITS-1:0] ev_x, ev_y, ev_adx, ev_ady;
  logic [RW-1:0]       ev_r;
  logic                ev_up, ev_dn;

  // running choice
  logic [DIM_BITS-1:0] ow, oh;
  logic [DIM_BITS:0]   best;
  logic [RW-1:0]       pick;
  logic                found;

  logic [DIM_BITS:0]   x_inc, y_inc, d;
  logic [DIM_BITS-1:0] adx, ady;
  logic                hit_up, hit_dn;

  // ceil(v / 2^(r+1)) = ceil(ceil(v / 2^r) / 2)
  assign x_inc  = {1'b0, x} + 1'b1;
  assign y_inc  = {1'b0, y} + 1'b1;
  assign adx    = (x >= rw) ? x - rw : rw - x;
  assign ady    = (y >= rh) ? y - rh : rh - y;
  assign hit_up = (x >= rw) && (y >= rh);
  assign hit_dn = (x <= rw) && (y <= rh);
  assign d      = {1'b0, ev_adx} + {1'b0, ev_ady};

  assign stat.last = (r == nl_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= req_type;
      rw   <= req_width[DIM_BITS-1:0];
      rh   <= req_height[DIM_BITS-1:0];
      x    <= image_width;
      y    <= image_height;
      r    <= '0;
      nl_q <= (level_count > MAX_LEVELS) ? RW'(MAX_LEVELS) : RW'(level_count);
    end else if (cmd.step) begin
      x <= x_inc[DIM_BITS:1];
      y <= y_inc[DIM_BITS:1];
      r <= r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ev_x   <= x;
      ev_y   <= y;
      ev_r   <= r;
      ev_adx <= adx;
      ev_ady <= ady;
      ev_up  <= hit_up;
      ev_dn  <= hit_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      if (ev_r == '0) begin
        pick  <= '0;
        ow    <= ev_x;
        oh    <= ev_y;
        best  <= d;
        found <= ev_dn;
      end else begin
        unique case (mode)
          rls_pkg::MODE_UP: begin
            if (ev_up) begin
              pick <= ev_r;
              ow   <= ev_x;
              oh   <= ev_y;
            end
          end
          rls_pkg::MODE_DOWN: begin
            if (!found) begin
              pick  <= ev_r;
              ow    <= ev_x;
              oh    <= ev_y;
              found <= ev_dn;
            end
          end
          default: begin
            if (d < best) begin
              pick <= ev_r;
              ow   <= ev_x;
              oh   <= ev_y;
              best <= d;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level      <= rls_pkg::LEVEL_W'(nl_q - pick);
      res_width  <= rls_pkg::FIELD_W'(ow);
      res_height <= rls_pkg::FIELD_W'(oh);
    end
  end

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (r <= nl_q))
    else $error("scan stepped past the level count");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    ev_valid |=> (pick <= nl_q))
    else $error("chosen reduction exceeds the level count");

  a_found_sticks: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && (ev_r != '0) && found) |=> found)
    else $error("round-down hit was lost");

endmodule

// ----- hw/rtl/resolution_level_selector.sv -----
// Channel   Dir  Beat fields (lowest bit up)                         Handshake
// s_*       in   tdata: req_type[1:0], req_width[32:2], req_height[63:33]   tvalid/tready
// m_*       out  tdata: level[5:0], res_width[36:6], res_height[67:37], zero[71:68]
// cfg_*     in   cfg_index: register index, cfg_data: value         cfg_valid/cfg_ready
//
// After accept, the scan evaluates one reduction per cycle, full size through the
// last level, through a shared halving and distance unit, then one flush and one commit.
// The next request is accepted the cycle after the commit, even while the previous result
// still waits in the output register.
// Reset (rst, synchronous) restores image 1x1, zero levels, and empties the pipe.
// A stalled output holds its beat; the commit waits until the output register frees.
module resolution_level_selector #(
  parameter int MAX_LEVELS = rls_pkg::MAX_LEVELS_DEF,
  parameter int DIM_BITS   = rls_pkg::DIM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request beat: req_type, req_width, req_height
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rls_pkg::IN_TDATA_W-1:0]   s_tdata,
  // result beat: level, res_width, res_height, zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rls_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rls_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PAD_W = rls_pkg::OUT_TDATA_W - rls_pkg::LEVEL_W - 2 * rls_pkg::FIELD_W;

  // configuration registers
  logic [DIM_BITS-1:0]         image_width;
  logic [DIM_BITS-1:0]         image_height;
  logic [rls_pkg::LEVEL_W-1:0] level_count;

  rls_pkg::rls_cmd_t  cmd;
  rls_pkg::rls_stat_t stat;

  logic [rls_pkg::LEVEL_W-1:0] level;
  logic [rls_pkg::FIELD_W-1:0] res_width;
  logic [rls_pkg::FIELD_W-1:0] res_height;

  // Always take configuration beats; the user must send them only while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_BITS'(1);
      image_height <= DIM_BITS'(1);
      level_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_index)
        rls_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_BITS-1:0];
        rls_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_BITS-1:0];
        rls_pkg::REG_LEVEL_COUNT:  level_count  <= cfg_data[rls_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  rls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rls_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .DIM_BITS   (DIM_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .image_width  (image_width),
    .image_height (image_height),
    .level_count  (level_count),
    .req_type     (s_tdata[1:0]),
    .req_width    (s_tdata[32:2]),
    .req_height   (s_tdata[63:33]),
    .level        (level),
    .res_width    (res_width),
    .res_height   (res_height)
  );

  // Pack the result beat, lowest field first, pad to whole bytes.
  assign m_tdata = {{PAD_W{1'b0}}, res_height, res_width, level};

endmodule

// ----- sim/tb_resolution_level_selector.sv -----
module tb_resolution_level_selector;

  localparam int FIELD_W     = rls_pkg::FIELD_W;
  localparam int LEVEL_W     = rls_pkg::LEVEL_W;
  localparam int REQ_TYPE_W  = rls_pkg::REQ_TYPE_W;
  localparam int IN_TDATA_W  = rls_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = rls_pkg::OUT_TDATA_W;
  localparam int CFG_INDEX_W = rls_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = rls_pkg::CFG_DATA_W;

  localparam logic [REQ_TYPE_W-1:0]  MODE_CLOSEST     = rls_pkg::MODE_CLOSEST;
  localparam logic [REQ_TYPE_W-1:0]  MODE_UP          = rls_pkg::MODE_UP;
  localparam logic [REQ_TYPE_W-1:0]  MODE_DOWN        = rls_pkg::MODE_DOWN;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = rls_pkg::REG_IMAGE_WIDTH;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = rls_pkg::REG_IMAGE_HEIGHT;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = rls_pkg::REG_LEVEL_COUNT;

  localparam logic [FIELD_W-1:0]     DIM_MAX    = {FIELD_W{1'b1}};
  localparam logic [REQ_TYPE_W-1:0]  MODE_SPARE = 2'd3;   // unused code, acts as closest
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 2'd3;   // no register behind it
  localparam int                     LEVEL_CAP  = 32;
  localparam int                     STALL_LIMIT = 2000;  // cycles with no beat anywhere
  localparam int                     DRAIN_CYCLES = 40;   // margin past the latency of one request
  localparam int                     PHASES     = 6;
  localparam int                     PHASE_ITEMS = 100;

  // One result beat: chosen level and the reduced image size that goes with it
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
  } level_pick_t;

  // One directed request together with the image setup it runs under
  typedef struct packed {
    logic [FIELD_W-1:0]    img_w;
    logic [FIELD_W-1:0]    img_h;
    logic [LEVEL_W-1:0]    levels;
    logic [REQ_TYPE_W-1:0] mode;
    logic [FIELD_W-1:0]    rw;
    logic [FIELD_W-1:0]    rh;
    logic                  typed;   // pick below is written out by hand
    level_pick_t           pick;
  } sel_case_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // req_type[1:0], req_width[32:2], req_height[63:33]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;    // level[5:0], res_width[36:6], res_height[67:37], pad
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Testbench copy of the image setup, updated on every accepted write
  logic [FIELD_W-1:0] img_width;
  logic [FIELD_W-1:0] img_height;
  logic [LEVEL_W-1:0] img_levels;

  level_pick_t pending_picks[$];   // predicted results, oldest first
  sel_case_t   sel_cases[$];
  int          errors;
  bit          calm;               // set to suppress idling on both sides

  resolution_level_selector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Size after r halvings, rounded up, at full precision
  function automatic logic [63:0] shrink(input logic [63:0] v, input int r);
    return (v + ((64'd1 << r) - 64'd1)) >> r;
  endfunction

  function automatic logic [63:0] absd(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Predict the level pick for one request under the current image setup
  function automatic level_pick_t pick_level(input logic [REQ_TYPE_W-1:0] mode,
                                             input logic [FIELD_W-1:0] rw,
                                             input logic [FIELD_W-1:0] rh);
    level_pick_t res;
    int          nl;
    int          r;
    int          pick;
    int          lev;
    bit          found;
    logic [63:0] w, h, x, y, ow, oh, best, d;
    nl    = (img_levels > LEVEL_CAP) ? LEVEL_CAP : int'(img_levels);
    w     = 64'(img_width);
    h     = 64'(img_height);
    ow    = w;
    oh    = h;
    pick  = 0;
    found = 1'b0;
    case (mode)
      MODE_UP: begin
        // scan from the smallest image up, stop at the first that covers
        for (r = nl; r >= 0; r--) begin
          if (!found) begin
            x = shrink(w, r);
            y = shrink(h, r);
            if (x >= 64'(rw) && y >= 64'(rh)) begin
              ow = x; oh = y; pick = r; found = 1'b1;
            end
          end
        end
        lev = found ? nl - pick : nl;
      end
      MODE_DOWN: begin
        // scan from full size down; with no fit the smallest reduction stays
        for (r = 0; r <= nl; r++) begin
          if (!found) begin
            x = shrink(w, r);
            y = shrink(h, r);
            ow = x; oh = y;
            if (x <= 64'(rw) && y <= 64'(rh)) begin
              pick = r; found = 1'b1;
            end
          end
        end
        lev = found ? nl - pick : 0;
      end
      default: begin
        best = absd(w, 64'(rw)) + absd(h, 64'(rh));
        for (r = 1; r <= nl; r++) begin
          x = shrink(w, r);
          y = shrink(h, r);
          d = absd(x, 64'(rw)) + absd(y, 64'(rh));
          if (d < best) begin
            best = d; ow = x; oh = y; pick = r;
          end
        end
        lev = nl - pick;
      end
    endcase
    res.level  = lev[LEVEL_W-1:0];
    res.width  = ow[FIELD_W-1:0];
    res.height = oh[FIELD_W-1:0];
    return res;
  endfunction

  function automatic sel_case_t mk_case(input logic [FIELD_W-1:0] iw, input logic [FIELD_W-1:0] ih,
                                        input logic [LEVEL_W-1:0] nl,
                                        input logic [REQ_TYPE_W-1:0] mode,
                                        input logic [FIELD_W-1:0] rw, input logic [FIELD_W-1:0] rh,
                                        input logic typed, input logic [LEVEL_W-1:0] lv,
                                        input logic [FIELD_W-1:0] ow, input logic [FIELD_W-1:0] oh);
    sel_case_t c;
    c.img_w = iw; c.img_h = ih; c.levels = nl;
    c.mode = mode; c.rw = rw; c.rh = rh;
    c.typed = typed;
    c.pick.level = lv; c.pick.width = ow; c.pick.height = oh;
    return c;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input sel_case_t c);
    sel_cases.insert(sel_cases.size(), c);
  endfunction

  // Random image dimension, weighted toward small sizes and the edges
  function automatic logic [FIELD_W-1:0] rand_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 31'd1;
      2:       return DIM_MAX;
      3, 4, 5: return 31'($urandom_range(1, 4096));
      default: return 31'($urandom);
    endcase
  endfunction

  // Request size a few pixels around the image size at one reduction
  function automatic logic [FIELD_W-1:0] near_size(input logic [FIELD_W-1:0] v, input int r);
    logic [63:0] base;
    int          off;
    base = shrink(64'(v), r);
    off  = int'($urandom_range(0, 6)) - 3;
    if (off < 0 && base < 64'(-off)) return '0;
    base = base + 64'(signed'(off));
    return (base > 64'(DIM_MAX)) ? DIM_MAX : base[FIELD_W-1:0];
  endfunction

  // Write one register; leave cfg_valid high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:  img_width  = val;
      REG_IMAGE_HEIGHT: img_height = val;
      REG_LEVEL_COUNT:  img_levels = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Stop sending and hold until every predicted beat has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  task automatic set_image(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] h,
                           input logic [LEVEL_W-1:0] nl);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LEVEL_COUNT, 31'(nl));
    cfg_valid <= 1'b0;
  endtask

  // Send one request beat; keep tvalid high afterward so back-to-back beats
  // never see a low and a high in the same step
  task automatic send_request(input logic [REQ_TYPE_W-1:0] mode, input logic [FIELD_W-1:0] rw,
                              input logic [FIELD_W-1:0] rh, input logic typed,
                              input level_pick_t hand_pick);
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rh, rw, mode};
    do @(posedge clk); while (!s_tready);
    // beat accepted at this edge: record what must come out for it
    pending_picks.insert(pending_picks.size(),
                         typed ? hand_pick : pick_level(mode, rw, rh));
  endtask

  // Result side: random back-pressure and the field-by-field check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_picks.size() == 0) begin
          $display("%0t: result beat with nothing expected: level %0d size %0d x %0d",
                   $time, m_tdata[5:0], m_tdata[36:6], m_tdata[67:37]);
          errors++;
        end else begin
          level_pick_t want;
          want = pending_picks.pop_front();
          if (m_tdata[5:0] !== want.level) begin
            $display("%0t: level expected %0d actual %0d", $time, want.level, m_tdata[5:0]);
            errors++;
          end
          if (m_tdata[36:6] !== want.width) begin
            $display("%0t: res_width expected %0d actual %0d", $time, want.width, m_tdata[36:6]);
            errors++;
          end
          if (m_tdata[67:37] !== want.height) begin
            $display("%0t: res_height expected %0d actual %0d", $time, want.height,
                     m_tdata[67:37]);
            errors++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    level_pick_t none;
    sel_case_t   c;
    int          nl;
    int          r;
    logic [REQ_TYPE_W-1:0] mode;
    logic [FIELD_W-1:0]    rw, rh;
    none       = '0;
    errors     = 0;
    calm       = 1'b0;
    img_width  = 31'd1;
    img_height = 31'd1;
    img_levels = '0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Rows under the reset setup come first and need no write.
    add_row(mk_case(1, 1, 0, MODE_CLOSEST, 0, 0, 1, 0, 1, 1));
    add_row(mk_case(1, 1, 0, MODE_UP, DIM_MAX, DIM_MAX, 1, 0, 1, 1));
    add_row(mk_case(1, 1, 0, MODE_DOWN, 0, 0, 1, 0, 1, 1));
    add_row(mk_case(1, 1, 0, MODE_SPARE, DIM_MAX, DIM_MAX, 1, 0, 1, 1));
    // 1024x768 with five levels: exact hits, nothing covers, nothing fits
    add_row(mk_case(1024, 768, 5, MODE_CLOSEST, 1024, 768, 1, 5, 1024, 768));
    add_row(mk_case(1024, 768, 5, MODE_CLOSEST, 32, 24, 1, 0, 32, 24));
    add_row(mk_case(1024, 768, 5, MODE_UP, 0, 0, 1, 0, 32, 24));
    add_row(mk_case(1024, 768, 5, MODE_UP, DIM_MAX, DIM_MAX, 1, 5, 1024, 768));
    add_row(mk_case(1024, 768, 5, MODE_DOWN, DIM_MAX, DIM_MAX, 1, 5, 1024, 768));
    add_row(mk_case(1024, 768, 5, MODE_DOWN, 0, 0, 1, 0, 32, 24));
    add_row(mk_case(1024, 768, 5, MODE_UP, 300, 200, 0, 0, 0, 0));
    add_row(mk_case(1024, 768, 5, MODE_DOWN, 300, 200, 0, 0, 0, 0));
    add_row(mk_case(1024, 768, 5, MODE_SPARE, 500, 400, 0, 0, 0, 0));
    // largest image, full level count
    add_row(mk_case(DIM_MAX, DIM_MAX, 32, MODE_CLOSEST, 0, 0, 0, 0, 0, 0));
    add_row(mk_case(DIM_MAX, DIM_MAX, 32, MODE_CLOSEST, DIM_MAX, DIM_MAX,
                    1, 32, DIM_MAX, DIM_MAX));
    add_row(mk_case(DIM_MAX, DIM_MAX, 32, MODE_UP, DIM_MAX, DIM_MAX,
                    1, 32, DIM_MAX, DIM_MAX));
    add_row(mk_case(DIM_MAX, DIM_MAX, 32, MODE_DOWN, 0, 0, 1, 0, 1, 1));
    add_row(mk_case(DIM_MAX, DIM_MAX, 32, MODE_DOWN, DIM_MAX, DIM_MAX,
                    1, 32, DIM_MAX, DIM_MAX));
    // zero-sized image: every reduction is 0 x 0
    add_row(mk_case(0, 0, 3, MODE_CLOSEST, 5, 5, 1, 3, 0, 0));
    add_row(mk_case(0, 0, 3, MODE_DOWN, 0, 0, 1, 3, 0, 0));
    add_row(mk_case(0, 0, 3, MODE_UP, 1, 1, 1, 3, 0, 0));
    // level count above the cap
    add_row(mk_case(1000, 1, 63, MODE_CLOSEST, 0, 0, 0, 0, 0, 0));
    add_row(mk_case(1000, 1, 63, MODE_UP, DIM_MAX, 0, 0, 0, 0, 0));
    add_row(mk_case(1000, 1, 63, MODE_DOWN, 7, 1, 0, 0, 0, 0));

    foreach (sel_cases[i]) begin
      c = sel_cases[i];
      if (c.img_w != img_width || c.img_h != img_height || c.levels != img_levels)
        set_image(c.img_w, c.img_h, c.levels);
      send_request(c.mode, c.rw, c.rh, c.typed, c.pick);
    end

    // Random part: one image setup per phase, edges in the first and last
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) write_reg(REG_SPARE, 31'($urandom));   // must change nothing
      case (ph)
        0: set_image(DIM_MAX, DIM_MAX, 6'd32);
        1: set_image(31'($urandom_range(1, 4096)), 31'($urandom_range(1, 4096)),
                     6'($urandom_range(0, 12)));
        2: set_image(rand_dim(), rand_dim(), 6'($urandom_range(33, 63)));
        5: set_image(31'd1, 31'd1, 6'd32);
        default: set_image(rand_dim(), rand_dim(),
                           ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                                                    : 6'($urandom_range(0, 32)));
      endcase
      calm = (ph == 3);
      nl = (img_levels > LEVEL_CAP) ? LEVEL_CAP : int'(img_levels);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mode = ($urandom_range(9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
        if ($urandom_range(99) < 70) begin
          // aim near one reduction so the scan has to decide close calls
          r  = $urandom_range(0, nl + 1);
          rw = near_size(img_width, r);
          rh = ($urandom_range(3) == 0) ? near_size(img_height, $urandom_range(0, nl + 1))
                                        : near_size(img_height, r);
        end else begin
          rw = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? '0 : DIM_MAX)
                                        : 31'($urandom);
          rh = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? '0 : DIM_MAX)
                                        : 31'($urandom);
        end
        send_request(mode, rw, rh, 1'b0, none);
      end
      calm = 1'b0;
    end

    // Drain: wait out every predicted beat, then a little past the latency
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rls_pkg.sv
hw/rtl/rls_ctrl.sv
hw/rtl/rls_dp.sv
hw/rtl/resolution_level_selector.sv
sim/tb_resolution_level_selector.sv
